/* sv/fmsr_pkg.sv */
// Shared constants, register codes and types for the first-match search and replace block.
package fmsr_pkg;

  // Longest pattern the window supports, and the width of the stream offset counter.
  localparam int MaxPattern  = 8;
  localparam int OffsetBits  = 32;
  localparam int MatchOffW   = 32;
  localparam int ByteW       = 8;
  localparam int RegW        = MaxPattern * ByteW;
  localparam int CfgLenW     = 4;
  localparam int CfgIdxW     = 2;
  // Counts that must hold MaxPattern itself.
  localparam int CntW        = $clog2(MaxPattern + 1);
  // Index into a pattern-sized vector.
  localparam int PIdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  // Held window bytes: at most one less than the pattern.
  localparam int WinDepth    = (MaxPattern > 1) ? MaxPattern - 1 : 1;
  // Output queue: a full flush plus one waiting result.
  localparam int QDepth      = MaxPattern + 1;
  localparam int QCntW       = $clog2(QDepth + 1);

  typedef logic [ByteW-1:0] byte_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegPattern     = 2'd0,
    RegReplacement = 2'd1,
    RegLength      = 2'd2,
    RegReplaceEn   = 2'd3
  } reg_idx_e;

  // Live configuration seen by the search core.
  typedef struct packed {
    logic [RegW-1:0]    pattern;
    logic [RegW-1:0]    repl;
    logic [CfgLenW-1:0] len;
    logic               repl_en;
  } cfg_t;

  // Results produced by one accepted byte.
  typedef struct packed {
    byte_t [MaxPattern-1:0] bytes;
    logic [CntW-1:0]        count;
    logic                   last;
    logic                   found;
    logic [MatchOffW-1:0]   offset;
  } res_t;

endpackage

/* sv/fmsr_core.sv */
// Window state, pattern compare and replacement for each accepted byte.
module fmsr_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fmsr_pkg::cfg_t             cfg_i,
  input  logic                       accept_i,
  input  fmsr_pkg::byte_t            data_byte_i,
  input  logic                       end_of_stream_i,
  output fmsr_pkg::res_t             res_o
);
  import fmsr_pkg::*;

  byte_t                 win_q [WinDepth];
  byte_t                 win_d [WinDepth];
  logic [CntW-1:0]       fill_q, fill_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic                  found_q, found_d;
  logic [OffsetBits-1:0] first_q, first_d;
  logic [CntW-1:0]       len_q;
  logic                  in_stream_q, in_stream_d;

  logic [CntW-1:0]       len;
  logic [CntW-1:0]       n;
  logic                  full;
  logic                  eq;
  logic                  hit;
  byte_t [MaxPattern-1:0] cur;
  byte_t [MaxPattern-1:0] cur_rep;
  logic [OffsetBits-1:0] off_new;
  logic                  found_now;
  logic [OffsetBits-1:0] off_now;

  // Out-of-range lengths fall back to the nearest legal value.
  function automatic logic [CntW-1:0] clamp_len(input logic [CfgLenW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) begin
      r = CntW'(1);
    end else if (v > CfgLenW'(MaxPattern)) begin
      r = CntW'(MaxPattern);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

  // The length is latched on the first byte of a stream.
  assign len  = in_stream_q ? len_q : clamp_len(cfg_i.len);
  assign n    = fill_q + CntW'(1);
  assign full = (n == len);

  // Assemble the current window: held bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      cur[i] = data_byte_i;
    end
    for (int i = 0; i < WinDepth; i++) begin
      if (CntW'(i) < fill_q) begin
        cur[i] = win_q[i];
      end
    end
  end

  // Compare the full window against the pattern, byte by byte in parallel.
  always_comb begin
    eq = 1'b1;
    for (int i = 0; i < MaxPattern; i++) begin
      if ((CntW'(i) < len) && (cur[i] != cfg_i.pattern[i*ByteW +: ByteW])) begin
        eq = 1'b0;
      end
    end
  end

  assign hit = full && !found_q && eq;

  // Overwrite the window with the replacement on the first match, when replacement is enabled.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      cur_rep[i] = (hit && cfg_i.repl_en) ? cfg_i.repl[i*ByteW +: ByteW] : cur[i];
    end
  end

  assign off_new   = pos_q - OffsetBits'(len - CntW'(1));
  assign found_now = found_q || hit;
  assign off_now   = hit ? off_new : first_q;

  // Results of this byte: the whole window on end of stream, else the oldest byte when full.
  always_comb begin
    res_o.bytes  = cur_rep;
    res_o.last   = end_of_stream_i;
    res_o.found  = found_now;
    res_o.offset = found_now ? MatchOffW'(off_now) : '0;
    if (end_of_stream_i) begin
      res_o.count = n;
    end else if (full) begin
      res_o.count = CntW'(1);
    end else begin
      res_o.count = '0;
    end
  end

  // Next window state.
  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    found_d     = found_q;
    first_d     = first_q;
    in_stream_d = in_stream_q;
    if (accept_i) begin
      if (end_of_stream_i) begin
        fill_d      = '0;
        pos_d       = '0;
        found_d     = 1'b0;
        first_d     = '0;
        in_stream_d = 1'b0;
      end else begin
        pos_d       = pos_q + OffsetBits'(1);
        found_d     = found_now;
        first_d     = off_now;
        in_stream_d = 1'b1;
        if (full) begin
          for (int i = 0; i < WinDepth; i++) begin
            win_d[i] = cur_rep[i+1];
          end
          fill_d = n - CntW'(1);
        end else begin
          for (int i = 0; i < WinDepth; i++) begin
            win_d[i] = cur_rep[i];
          end
          fill_d = n;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      first_q     <= '0;
      len_q       <= CntW'(1);
      in_stream_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      first_q     <= first_d;
      in_stream_q <= in_stream_d;
      if (accept_i) begin
        len_q <= len;
      end
    end
  end

  // Held window bytes are payload and need no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

/* sv/fmsr_obuf.sv */
// Output queue that holds result bytes until the downstream side takes them.
module fmsr_obuf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  fmsr_pkg::res_t                  res_i,
  output logic                            space_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fmsr_pkg::byte_t                 out_byte_o,
  output logic                            out_last_o,
  output logic                            match_found_o,
  output logic [fmsr_pkg::MatchOffW-1:0]  match_offset_o
);
  import fmsr_pkg::*;

  byte_t                q_byte_q [QDepth];
  byte_t                q_byte_d [QDepth];
  logic [QDepth-1:0]    q_last_q, q_last_d;
  logic [QCntW-1:0]     cnt_q, cnt_d;
  logic                 lastpend_q, lastpend_d;
  logic                 meta_found_q;
  logic [MatchOffW-1:0] meta_off_q;

  logic                 drain;
  logic                 last_out;
  logic [QCntW-1:0]     base;
  logic [QCntW-1:0]     idx;

  // Head of the queue drives the output channel.
  assign out_valid_o    = (cnt_q != '0);
  assign out_byte_o     = q_byte_q[0];
  assign out_last_o     = q_last_q[0];
  assign match_found_o  = q_last_q[0] && meta_found_q;
  assign match_offset_o = q_last_q[0] ? meta_off_q : '0;

  assign drain    = out_valid_o && out_ready_i;
  assign last_out = drain && q_last_q[0];
  assign base     = cnt_q - QCntW'(drain);

  // Room for a full flush, and at most one end of stream in the queue.
  assign space_o = ((QCntW+1)'(base) + (QCntW+1)'(MaxPattern) <= (QCntW+1)'(QDepth))
                   && !(lastpend_q && !last_out);

  // Shift out on a transfer, then append the new results behind what remains.
  always_comb begin
    idx = '0;
    for (int j = 0; j < QDepth; j++) begin
      if (drain && (j < QDepth - 1)) begin
        q_byte_d[j] = q_byte_q[(j < QDepth - 1) ? j + 1 : j];
        q_last_d[j] = q_last_q[(j < QDepth - 1) ? j + 1 : j];
      end else if (drain) begin
        q_byte_d[j] = q_byte_q[j];
        q_last_d[j] = 1'b0;
      end else begin
        q_byte_d[j] = q_byte_q[j];
        q_last_d[j] = q_last_q[j];
      end
    end
    if (push_i) begin
      for (int j = 0; j < QDepth; j++) begin
        idx = QCntW'(j) - base;
        if ((QCntW'(j) >= base) && (idx < QCntW'(res_i.count))) begin
          q_byte_d[j] = res_i.bytes[idx[PIdxW-1:0]];
          q_last_d[j] = res_i.last && (idx == QCntW'(res_i.count) - QCntW'(1));
        end
      end
    end
    cnt_d = base + (push_i ? QCntW'(res_i.count) : '0);
  end

  // Track whether an end-of-stream result is waiting in the queue.
  always_comb begin
    lastpend_d = lastpend_q;
    if (last_out) begin
      lastpend_d = 1'b0;
    end
    if (push_i && res_i.last) begin
      lastpend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      q_last_q   <= '0;
      lastpend_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      q_last_q   <= q_last_d;
      lastpend_q <= lastpend_d;
    end
  end

  // Queue bytes and match summary are payload.
  always_ff @(posedge clk_i) begin
    q_byte_q <= q_byte_d;
    if (push_i && res_i.last) begin
      meta_found_q <= res_i.found;
      meta_off_q   <= res_i.offset;
    end
  end

  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("output queue overflow");

  // A final byte at the head always has its match summary recorded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> lastpend_q)
    else $error("final byte without pending end of stream");

  // An empty queue holds no pending end of stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !lastpend_q)
    else $error("pending end of stream in empty queue");

  // A transfer that is not the final byte keeps the pending end of stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lastpend_q && drain && !q_last_q[0] && !push_i) |=> lastpend_q)
    else $error("pending end of stream lost");

endmodule

/* sv/first_match_search_replace.sv */
// Top level of the streaming first-match search and replace block.
// The block takes one byte per clock and finds the first place in each stream where the configured
// pattern (1 to 8 bytes) occurs, optionally overwriting it once with the replacement bytes. A byte
// leaves once pattern length minus one later bytes have come in, so a non-final byte pushes zero or
// one result into the queue with its transfer. The final byte of a stream flushes the whole window,
// up to pattern length results, which the output queue hands out one per clock while out_ready_i
// is high; the final result carries the match flag and offset. Input is taken while the queue,
// after this cycle's output transfer, holds at most one result and no earlier end of stream, so the
// sustained rate is one byte per clock apart from output stalls and each stream's flush drain.
// Configuration is written through the plain write port; the user must write it only while the
// block is idle (the block does not enforce it); pattern length latches on a stream's first byte.
module first_match_search_replace (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmsr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fmsr_pkg::RegW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fmsr_pkg::byte_t                    data_byte_i,
  input  logic                               end_of_stream_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fmsr_pkg::byte_t                    out_byte_o,
  output logic                               out_last_o,
  output logic                               match_found_o,
  output logic [fmsr_pkg::MatchOffW-1:0]     match_offset_o
);
  import fmsr_pkg::*;

  cfg_t cfg_q;
  res_t res;
  logic accept;
  logic space;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.repl    <= '0;
      cfg_q.len     <= CfgLenW'(1);
      cfg_q.repl_en <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegPattern:     cfg_q.pattern <= cfg_data_i;
        RegReplacement: cfg_q.repl    <= cfg_data_i;
        RegLength:      cfg_q.len     <= cfg_data_i[CfgLenW-1:0];
        RegReplaceEn:   cfg_q.repl_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // An input transfer happens when the queue has room for a full flush and no earlier end of stream.
  assign in_ready_o = space;
  assign accept     = in_valid_i && in_ready_o;

  fmsr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .res_o           (res)
  );

  fmsr_obuf u_obuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (accept),
    .res_i          (res),
    .space_o        (space),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .match_found_o  (match_found_o),
    .match_offset_o (match_offset_o)
  );

endmodule

/* dv/tb_first_match_search_replace.sv */
// Self-checking testbench for the streaming first-match search and replace block.
module tb_first_match_search_replace;
  import fmsr_pkg::*;

  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 3;
  localparam int MaxGap       = 11;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 16;
  localparam int QuietLimit   = 2000;
  localparam int RandomItems  = 500;

  // One byte leaving the block, with the stream-end fields.
  typedef struct {
    byte_t                data;
    logic                 last;
    logic                 found;
    logic [MatchOffW-1:0] offset;
  } out_beat_t;

  typedef enum logic {RowCfg, RowByte} row_kind_e;

  // One line of the directed stimulus table.
  typedef struct {
    row_kind_e       kind;
    reg_idx_e        idx;
    logic [RegW-1:0] value;
    byte_t           data;
    logic            eos;
    bit              typed;
    out_beat_t       want;
  } stim_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i     = '0;
  logic [RegW-1:0]      cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  byte_t                data_byte_i     = '0;
  logic                 end_of_stream_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  byte_t                out_byte_o;
  logic                 out_last_o;
  logic                 match_found_o;
  logic [MatchOffW-1:0] match_offset_o;

  // Register copies and per-stream search state of the predictor.
  logic [RegW-1:0]       cfg_pattern  = '0;
  logic [RegW-1:0]       cfg_repl     = '0;
  logic [CfgLenW-1:0]    cfg_len      = CfgLenW'(1);
  logic                  cfg_repl_en  = 1'b1;
  byte_t                 held[MaxPattern];
  int unsigned           held_cnt     = 0;
  int unsigned           latched_len  = 1;
  bit                    stream_open  = 1'b0;
  logic [OffsetBits-1:0] stream_pos   = '0;
  bit                    match_seen   = 1'b0;
  logic [OffsetBits-1:0] match_at     = '0;

  out_beat_t   due_out[$];
  stim_row_t   rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  first_match_search_replace dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .match_found_o  (match_found_o),
    .match_offset_o (match_offset_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Lengths of 0 behave as 1, and lengths past the window behave as the full window.
  function automatic int unsigned clamp_len(logic [CfgLenW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxPattern) return MaxPattern;
    return int'(v);
  endfunction

  // Advance the search by one accepted byte and queue the bytes it releases.
  function automatic void search_replace_step(byte_t d, logic eos);
    byte_t       cur[MaxPattern];
    int unsigned n;
    int unsigned plen;
    bit          eq;
    out_beat_t   beat;
    if (!stream_open) begin
      latched_len = clamp_len(cfg_len);
      stream_open = 1'b1;
    end
    plen = latched_len;
    for (int unsigned i = 0; i < held_cnt; i++) cur[i] = held[i];
    cur[held_cnt] = d;
    n = held_cnt + 1;

    // Only the first full-window match of a stream counts.
    if (n == plen && !match_seen) begin
      eq = 1'b1;
      for (int unsigned i = 0; i < plen; i++) begin
        if (cur[i] != cfg_pattern[ByteW*i +: ByteW]) eq = 1'b0;
      end
      if (eq) begin
        match_seen = 1'b1;
        match_at   = stream_pos - OffsetBits'(plen - 1);
        if (cfg_repl_en) begin
          for (int unsigned i = 0; i < plen; i++) cur[i] = cfg_repl[ByteW*i +: ByteW];
        end
      end
    end
    stream_pos = stream_pos + 1'b1;

    if (eos) begin
      // Flush the whole window; the final byte carries the match report.
      for (int unsigned i = 0; i < n; i++) begin
        beat.data   = cur[i];
        beat.last   = (i == n - 1);
        beat.found  = beat.last && match_seen;
        beat.offset = beat.found ? MatchOffW'(match_at) : '0;
        due_out.push_back(beat);
      end
      held_cnt    = 0;
      stream_pos  = '0;
      match_seen  = 1'b0;
      match_at    = '0;
      stream_open = 1'b0;
    end else if (n == plen) begin
      beat.data   = cur[0];
      beat.last   = 1'b0;
      beat.found  = 1'b0;
      beat.offset = '0;
      due_out.push_back(beat);
      for (int unsigned i = 1; i < n; i++) held[i-1] = cur[i];
      held_cnt = n - 1;
    end else begin
      held[held_cnt] = d;
      held_cnt       = n;
    end
  endfunction

  function automatic void cfg_row(reg_idx_e idx, logic [RegW-1:0] v);
    stim_row_t r;
    r.kind  = RowCfg;
    r.idx   = idx;
    r.value = v;
    r.data  = '0;
    r.eos   = 1'b0;
    r.typed = 1'b0;
    r.want  = '{data: '0, last: 1'b0, found: 1'b0, offset: '0};
    rows.push_back(r);
  endfunction

  // A byte row; when typed, the final released byte is checked against the given fields.
  function automatic void byte_row(byte_t d, logic eos, bit typed, byte_t wb, logic wl,
                                   logic wf, logic [MatchOffW-1:0] wo);
    stim_row_t r;
    r.kind        = RowByte;
    r.idx         = RegPattern;
    r.value       = '0;
    r.data        = d;
    r.eos         = eos;
    r.typed       = typed;
    r.want.data   = wb;
    r.want.last   = wl;
    r.want.found  = wf;
    r.want.offset = wo;
    rows.push_back(r);
  endfunction

  function automatic logic [RegW-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Present one byte after a random gap and hold it until the transfer.
  task automatic send_byte(byte_t d, logic eos, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, MaxGap) : 0;
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= d;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    search_replace_step(d, eos);
  endtask

  // Stop input and let every released byte leave before touching the registers.
  task automatic wait_outputs_drained();
    in_valid_i <= 1'b0;
    while (due_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [RegW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    case (idx)
      RegPattern:     cfg_pattern = v;
      RegReplacement: cfg_repl    = v;
      RegLength:      cfg_len     = v[CfgLenW-1:0];
      RegReplaceEn:   cfg_repl_en = v[0];
      default:        ;
    endcase
  endtask

  // Output side: random stalls, with stretches where ready stays high.
  initial begin : out_side
    int unsigned stall;
    int unsigned mode_left;
    bit          stalls_on;
    mode_left = 0;
    stalls_on = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      stall = stalls_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Compare every output transfer with the oldest byte due.
  always @(posedge clk_i) begin : out_check
    out_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (due_out.size() == 0) begin
        flag_mismatch($sformatf("output byte %02h with nothing due", out_byte_o));
      end else begin
        want = due_out.pop_front();
        if (out_byte_o !== want.data)
          flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
        if (out_last_o !== want.last)
          flag_mismatch($sformatf("out_last %b, want %b", out_last_o, want.last));
        if (match_found_o !== want.found)
          flag_mismatch($sformatf("match_found %b, want %b", match_found_o, want.found));
        if (match_offset_o !== want.offset)
          flag_mismatch($sformatf("match_offset %0d, want %0d", match_offset_o, want.offset));
      end
    end
  end

  // Watchdog: a long run of cycles without any transfer means the block hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned     n_random;
    int unsigned     n_str;
    int unsigned     slen;
    int unsigned     start;
    int unsigned     plen;
    bit              plant;
    bit              gaps_on;
    bit              after_bytes;
    logic            eos;
    byte_t           b;
    logic [RegW-1:0] len_val;
    n_random    = 0;
    after_bytes = 1'b0;

    // Directed table. Reset state: pattern zero, replacement zero, length 1, replace on.
    byte_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 32'd0);
    byte_row(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 32'd0);
    cfg_row(RegPattern, 64'h5A);
    cfg_row(RegReplacement, 64'hA5);
    byte_row(8'h11, 1'b0, 1'b1, 8'h11, 1'b0, 1'b0, 32'd0);
    byte_row(8'h5A, 1'b1, 1'b1, 8'hA5, 1'b1, 1'b1, 32'd1);
    // All-ones pattern, search only, out-of-range length that acts as the full window.
    cfg_row(RegPattern, '1);
    cfg_row(RegReplacement, '0);
    cfg_row(RegReplaceEn, 64'd0);
    cfg_row(RegLength, 64'd15);
    for (int i = 0; i < 7; i++) byte_row(8'hFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 32'd0);
    // A stream shorter than the pattern never matches.
    byte_row(8'hFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 32'd0);
    // Length zero acts as one.
    cfg_row(RegLength, 64'd0);
    cfg_row(RegReplaceEn, 64'd1);
    byte_row(8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 32'd0);
    // A length write in the middle of a stream waits for the next stream.
    cfg_row(RegLength, 64'd2);
    byte_row(8'h01, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
    cfg_row(RegLength, 64'd4);
    byte_row(8'hFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
    byte_row(8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 32'd1);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].kind == RowCfg) begin
        if (after_bytes) wait_outputs_drained();
        after_bytes = 1'b0;
        cfg_write(rows[k].idx, rows[k].value);
      end else begin
        after_bytes = 1'b1;
        send_byte(rows[k].data, rows[k].eos, 1'b1);
        if (rows[k].typed) due_out[due_out.size()-1] = rows[k].want;
      end
    end

    // Random phases: a fresh setting, then streams rich in pattern bytes and planted matches.
    // The last stream of a phase is sometimes left open across the next register writes.
    while (n_random < RandomItems) begin
      wait_outputs_drained();
      len_val = ($urandom_range(0, 3) == 0) ? RegW'($urandom_range(0, 15))
                                            : RegW'($urandom_range(1, 8));
      cfg_write(RegPattern, pick_reg_value());
      cfg_write(RegReplacement, pick_reg_value());
      cfg_write(RegLength, len_val);
      cfg_write(RegReplaceEn, RegW'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      n_str   = $urandom_range(1, 6);
      for (int unsigned s = 0; s < n_str; s++) begin
        plen  = clamp_len(cfg_len);
        slen  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        plant = ($urandom_range(0, 1) == 1) && (slen >= plen);
        start = plant ? $urandom_range(0, slen - plen) : 0;
        for (int unsigned k = 0; k < slen; k++) begin
          if (plant && k >= start && k < start + plen)
            b = cfg_pattern[ByteW*(k-start) +: ByteW];
          else if ($urandom_range(0, 3) == 0)
            b = byte_t'($urandom);
          else
            b = cfg_pattern[ByteW*$urandom_range(0, plen - 1) +: ByteW];
          eos = (k == slen - 1) && !(s == n_str - 1 && $urandom_range(0, 3) == 0);
          send_byte(b, eos, gaps_on);
          n_random++;
        end
      end
    end
    if (stream_open) send_byte(byte_t'($urandom), 1'b1, 1'b1);

    wait_outputs_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* first_match_search_replace.f */
sv/fmsr_pkg.sv
sv/fmsr_core.sv
sv/fmsr_obuf.sv
sv/first_match_search_replace.sv
dv/tb_first_match_search_replace.sv
